>>> rtl/fwprl_pkg.sv
`default_nettype none

package fwprl_pkg;

   // Number of special slots that take part in matching, and the number stored.
   localparam int SpecialSlots = 3;
   localparam int SlotMax      = 3;

   localparam int TypeWidth     = 16;
   localparam int TimeWidth     = 32;
   localparam int CountWidth    = 32;
   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth  = 32;

   // Register map of the configuration port.
   localparam logic [CsrIndexWidth-1:0] RegGlobalLimit = 8'd0;
   localparam logic [CsrIndexWidth-1:0] RegSlotEnable  = 8'd1;
   localparam logic [CsrIndexWidth-1:0] RegSlotType0   = 8'd2;
   localparam logic [CsrIndexWidth-1:0] RegSlotType1   = 8'd3;
   localparam logic [CsrIndexWidth-1:0] RegSlotType2   = 8'd4;
   localparam logic [CsrIndexWidth-1:0] RegSlotLimit0  = 8'd5;
   localparam logic [CsrIndexWidth-1:0] RegSlotLimit1  = 8'd6;
   localparam logic [CsrIndexWidth-1:0] RegSlotLimit2  = 8'd7;

   typedef struct packed {
      logic [CountWidth-1:0]                 global_limit;
      logic [SlotMax-1:0]                    slot_enable;
      logic [SlotMax-1:0][TypeWidth-1:0]     slot_type;
      logic [SlotMax-1:0][CountWidth-1:0]    slot_limit;
   } cfg_type;

   typedef struct packed {
      logic               global_count;
      logic [SlotMax-1:0] slot_count;
   } clr_type;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] value);
      return (value == {CountWidth{1'b1}}) ? value : value + CountWidth'(1);
   endfunction

endpackage

`default_nettype wire

>>> rtl/fwprl_if.sv
`default_nettype none

interface fwprl_req_if;
   import fwprl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [TypeWidth-1:0] packet_type;
   logic [TimeWidth-1:0] current_time;

   modport source (output valid, output packet_type, output current_time, input ready);
   modport sink   (input valid, input packet_type, input current_time, output ready);
endinterface

interface fwprl_rsp_if;
   logic valid;
   logic ready;
   logic drop;

   modport source (output valid, output drop, input ready);
   modport sink   (input valid, input drop, output ready);
endinterface

interface fwprl_csr_if;
   import fwprl_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/fwprl_csr.sv
`default_nettype none

module fwprl_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   fwprl_csr_if.sink          csr_bus,
   output fwprl_pkg::cfg_type cfg,
   output fwprl_pkg::clr_type clr
);
   import fwprl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   assign csr_bus.ready = 1'b1;
   assign write         = csr_bus.valid;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      clr    = '0;
      if (write) begin
         unique case (csr_bus.index)
            RegGlobalLimit: begin
               cfg_in.global_limit = csr_bus.data;
               clr.global_count    = 1'b1;
            end
            RegSlotEnable: begin
               cfg_in.slot_enable = csr_bus.data[SlotMax-1:0];
               // Only slots that switch on start from a clean count.
               clr.slot_count     = csr_bus.data[SlotMax-1:0] & ~cfg_ff.slot_enable;
            end
            RegSlotType0: begin
               cfg_in.slot_type[0] = csr_bus.data[TypeWidth-1:0];
               clr.slot_count[0]   = 1'b1;
            end
            RegSlotType1: begin
               cfg_in.slot_type[1] = csr_bus.data[TypeWidth-1:0];
               clr.slot_count[1]   = 1'b1;
            end
            RegSlotType2: begin
               cfg_in.slot_type[2] = csr_bus.data[TypeWidth-1:0];
               clr.slot_count[2]   = 1'b1;
            end
            RegSlotLimit0: begin
               cfg_in.slot_limit[0] = csr_bus.data;
               clr.slot_count[0]    = 1'b1;
            end
            RegSlotLimit1: begin
               cfg_in.slot_limit[1] = csr_bus.data;
               clr.slot_count[1]    = 1'b1;
            end
            RegSlotLimit2: begin
               cfg_in.slot_limit[2] = csr_bus.data;
               clr.slot_count[2]    = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fwprl_core.sv
`default_nettype none

module fwprl_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  fwprl_pkg::cfg_type cfg,
   input  fwprl_pkg::clr_type clr,
   fwprl_req_if.sink          req_bus,
   fwprl_rsp_if.source        rsp_bus
);
   import fwprl_pkg::*;

   logic [TimeWidth-1:0]               window_time_ff;
   logic [TimeWidth-1:0]               window_time_in;
   logic [CountWidth-1:0]              global_count_ff;
   logic [CountWidth-1:0]              global_count_in;
   logic [SlotMax-1:0][CountWidth-1:0] slot_count_ff;
   logic [SlotMax-1:0][CountWidth-1:0] slot_count_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic                               drop_ff;
   logic                               drop_in;

   logic                               accept;
   logic                               new_window;
   logic [CountWidth-1:0]              global_next;
   logic                               global_drop;
   logic [SlotMax-1:0]                 slot_hit;
   logic [SlotMax-1:0]                 slot_sel;
   logic [SlotMax-1:0][CountWidth-1:0] slot_next;
   logic [SlotMax-1:0]                 slot_drop;
   logic                               found;

   // The result register frees up whenever its content is taken.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.drop  = drop_ff;

   assign new_window  = req_bus.current_time != window_time_ff;
   assign global_next = sat_inc(new_window ? '0 : global_count_ff);
   assign global_drop = global_next > cfg.global_limit;

   always_comb begin
      found    = 1'b0;
      slot_sel = '0;
      for (int k = 0; k < SlotMax; k++) begin
         slot_hit[k]  = (k < SpecialSlots) && cfg.slot_enable[k]
                        && (cfg.slot_type[k] == req_bus.packet_type);
         slot_next[k] = sat_inc(new_window ? '0 : slot_count_ff[k]);
         slot_drop[k] = slot_next[k] > cfg.slot_limit[k];
         if (slot_hit[k] && !found) begin
            slot_sel[k] = 1'b1;
            found       = 1'b1;
         end
      end
   end

   always_comb begin
      window_time_in  = window_time_ff;
      global_count_in = global_count_ff;
      slot_count_in   = slot_count_ff;
      drop_in         = drop_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      if (accept) begin
         window_time_in  = req_bus.current_time;
         global_count_in = global_next;
         drop_in         = global_drop || (|(slot_sel & slot_drop));
         rsp_valid_in    = 1'b1;
         for (int k = 0; k < SlotMax; k++) begin
            if (slot_sel[k] && !global_drop) begin
               slot_count_in[k] = slot_next[k];
            end else if (new_window) begin
               slot_count_in[k] = '0;
            end
         end
      end
      if (clr.global_count) begin
         global_count_in = '0;
      end
      for (int k = 0; k < SlotMax; k++) begin
         if (clr.slot_count[k]) begin
            slot_count_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_time_ff  <= '0;
         global_count_ff <= '0;
         slot_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         window_time_ff  <= window_time_in;
         global_count_ff <= global_count_in;
         slot_count_ff   <= slot_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drop_ff <= drop_in;
   end

endmodule

`default_nettype wire

>>> rtl/fixed_window_packet_rate_limiter.sv
// Fixed-window packet policer.
// The request channel carries one transaction per packet: its type and the current
// time. The response channel returns one transaction per request, carrying drop = 1
// when the packet is over the global limit or over the limit of the first enabled
// special slot whose type matches. A change of time opens a new window and clears
// every counter before the packet is counted; counters saturate at all ones.
// The response is valid in the cycle after the request is accepted. Throughput
// is one transaction per cycle while responses are taken, set by the single pass
// of compare, increment and match between the counters and the response register.
// When the receiver stalls, the response register holds its transaction and one
// further request is still taken in the cycle it is read out; otherwise req ready
// drops until the response is taken.
// The configuration port is always ready and writes take effect in the following
// cycle. Writes to a limit, type or enable register clear the counters they affect;
// writes to an index beyond the register map are ignored.
// Synchronous reset clears the configuration registers, counters, the window time
// and the response valid flag; the drop flag is not reset.
`default_nettype none

module fixed_window_packet_rate_limiter (
   input  wire logic   clock,
   input  wire logic   reset,
   fwprl_req_if.sink   req_bus,
   fwprl_rsp_if.source rsp_bus,
   fwprl_csr_if.sink   csr_bus
);
   import fwprl_pkg::*;

   // Configuration registers and the counter clears that writes cause.
   cfg_type cfg;
   clr_type clr;

   fwprl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg),
      .clr     (clr)
   );

   // Window tracking, counters and the response register.
   fwprl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .clr     (clr),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

>>> tb/sv/packet_drop_checker.sv
module packet_drop_checker (
   input  logic  clock,
   input  logic  reset,
   fwprl_req_if  req,
   fwprl_rsp_if  rsp,
   fwprl_csr_if  csr,
   output int    outstanding,
   output int    mismatches
);
   timeunit 1ns;
   timeprecision 1ps;
   import fwprl_pkg::*;

   localparam int MaxReported    = 10;
   localparam int SlotIndexWidth = $clog2(SlotMax);

   cfg_type               limits_cfg;
   logic [TimeWidth-1:0]  window_time;
   logic [CountWidth-1:0] global_count;
   logic [CountWidth-1:0] slot_count [SlotMax];
   logic                  expected_drops [$];
   logic                  predicted;
   int                    failure_total = 0;

   function automatic logic [CountWidth-1:0] bump(input logic [CountWidth-1:0] count);
      return (&count) ? count : count + 1'b1;
   endfunction

   function automatic void clear_window_counts();
      global_count = '0;
      for (int k = 0; k < SlotMax; k++) slot_count[k] = '0;
   endfunction

   function automatic void write_register(input logic [CsrIndexWidth-1:0] index,
                                          input logic [CsrDataWidth-1:0]  data);
      logic [SlotMax-1:0]        turned_on;
      logic [SlotIndexWidth-1:0] slot;
      turned_on = data[SlotMax-1:0] & ~limits_cfg.slot_enable;
      case (index)
         RegGlobalLimit: begin
            limits_cfg.global_limit = data;
            global_count = '0;
         end
         RegSlotEnable: begin
            // Only slots that switch from off to on start counting afresh.
            for (int k = 0; k < SlotMax; k++)
               if (turned_on[k]) slot_count[k] = '0;
            limits_cfg.slot_enable = data[SlotMax-1:0];
         end
         RegSlotType0, RegSlotType1, RegSlotType2: begin
            slot = SlotIndexWidth'(index - RegSlotType0);
            limits_cfg.slot_type[slot] = data[TypeWidth-1:0];
            slot_count[slot] = '0;
         end
         RegSlotLimit0, RegSlotLimit1, RegSlotLimit2: begin
            slot = SlotIndexWidth'(index - RegSlotLimit0);
            limits_cfg.slot_limit[slot] = data;
            slot_count[slot] = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic logic police_packet(input logic [TypeWidth-1:0] ptype,
                                          input logic [TimeWidth-1:0] now);
      logic dropped;
      logic matched;
      dropped = 1'b0;
      matched = 1'b0;
      if (now != window_time) begin
         clear_window_counts();
         window_time = now;
      end
      global_count = bump(global_count);
      if (global_count > limits_cfg.global_limit) begin
         dropped = 1'b1;
      end else begin
         // The lowest enabled slot holding this type is the only one charged.
         for (int k = 0; k < SpecialSlots; k++) begin
            if (!matched && limits_cfg.slot_enable[k] && limits_cfg.slot_type[k] == ptype) begin
               matched = 1'b1;
               slot_count[k] = bump(slot_count[k]);
               dropped = slot_count[k] > limits_cfg.slot_limit[k];
            end
         end
      end
      return dropped;
   endfunction

   function automatic void note_failure(input string what);
      failure_total++;
      if (failure_total <= MaxReported) $display("%0t ns: %s", $time, what);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         limits_cfg = '0;
         window_time = '0;
         clear_window_counts();
         expected_drops.delete();
      end else begin
         if (csr.valid && csr.ready) write_register(csr.index, csr.data);
         if (rsp.valid && rsp.ready) begin
            if (expected_drops.size() == 0) begin
               note_failure($sformatf("response drop=%0b with no request outstanding",
                                      rsp.drop));
            end else begin
               predicted = expected_drops.pop_front();
               if (rsp.drop !== predicted)
                  note_failure($sformatf("drop mismatch: expected %0b, got %0b",
                                         predicted, rsp.drop));
            end
         end
         if (req.valid && req.ready)
            expected_drops.push_back(police_packet(req.packet_type, req.current_time));
      end
      outstanding <= expected_drops.size();
      mismatches  <= failure_total;
   end

endmodule

>>> tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fwprl_pkg::*;

   // Random stimulus volume, overall cycle budget and the settle time after the
   // last response before the block is treated as idle.
   localparam int RandomItems = 1950;
   localparam int CycleLimit  = 400000;
   localparam int TailCycles  = 3;
   localparam int PoolSize    = 4;
   localparam int MaxBurst    = 24;
   localparam int MaxGap      = 6;

   // Indexes past the register map; writes there must leave every register alone.
   localparam logic [CsrIndexWidth-1:0] FirstUnusedReg = RegSlotLimit2 + 1'b1;
   localparam logic [CsrIndexWidth-1:0] LastCsrIndex   = '1;

   typedef enum logic [1:0] {
      StallNone,
      StallRandom,
      StallPeriodic,
      StallHeavy
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset;

   fwprl_req_if req_chan ();
   fwprl_rsp_if rsp_chan ();
   fwprl_csr_if csr_chan ();

   int outstanding;
   int mismatches;
   int cycle_count = 0;

   stall_mode_type stall_mode = StallNone;
   int             stall_left = 0;

   logic [TypeWidth-1:0] type_pool [PoolSize];
   logic [TimeWidth-1:0] now_time;
   logic [TimeWidth-1:0] prev_time;
   logic [TimeWidth-1:0] next_time;
   int                   window_left;
   int                   burst_left;
   int                   phase_items;
   int                   random_sent;
   bit                   gappy;

   fixed_window_packet_rate_limiter uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_chan),
      .rsp_bus (rsp_chan),
      .csr_bus (csr_chan)
   );

   packet_drop_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr         (csr_chan),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The response side stalls on its own schedule, independent of the sender. It
   // switches between always ready, coin-flip ready, a fixed one-in-three stall
   // and long stretches where it is almost never ready.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(30, 150);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         StallNone:     rsp_chan.ready <= 1'b1;
         StallRandom:   rsp_chan.ready <= 1'($urandom_range(0, 1));
         StallPeriodic: rsp_chan.ready <= (cycle_count % 3) != 0;
         StallHeavy:    rsp_chan.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Offers one packet and returns at the edge where the transaction is taken.
   // Valid is left high so that a following packet can go out back to back.
   task automatic send_packet(input logic [TypeWidth-1:0] ptype,
                              input logic [TimeWidth-1:0] stamp);
      req_chan.valid        <= 1'b1;
      req_chan.packet_type  <= ptype;
      req_chan.current_time <= stamp;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Stops sending and waits until every response has come back, then lets the
   // pipeline settle so that register writes land on an idle block.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
   endtask

   // Register writes are issued back to back; csr_idle closes a group of them.
   task automatic csr_write(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0]  data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
   endtask

   task automatic csr_idle();
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Limits are mostly small so that drops are frequent, with the extremes and
   // full-range values mixed in.
   function automatic logic [CountWidth-1:0] pick_limit(input int typical);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return CountWidth'($urandom);
         default: return CountWidth'($urandom_range(1, typical));
      endcase
   endfunction

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.packet_type  = '0;
      req_chan.current_time = '0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = '0;
      csr_chan.data         = '0;
      reset                 = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset the global limit is zero, so every packet is dropped, at both
      // ends of the type and time ranges.
      send_packet('0, '0);
      send_packet('1, '1);
      drain();

      // Slot zero and one enabled through a value with junk in the upper bits; slots
      // one and two share a type so the lower one must win. Two of the type writes carry
      // junk above bit 15. Writes past the map alias registers zero and seven under
      // a narrow decode, and would break the checks below if they were taken.
      csr_write(RegGlobalLimit, 32'd4);
      csr_write(RegSlotEnable, 32'hFFFF_FFFB);
      csr_write(RegSlotType0, 32'hDEAD_0000);
      csr_write(RegSlotType1, 32'h0000_FFFF);
      csr_write(RegSlotType2, 32'h1234_FFFF);
      csr_write(RegSlotLimit0, 32'd1);
      csr_write(RegSlotLimit1, 32'd0);
      csr_write(RegSlotLimit2, 32'hFFFF_FFFF);
      csr_write(FirstUnusedReg, 32'd0);
      csr_write(LastCsrIndex, 32'd0);
      csr_idle();

      // One window: slot zero passes once then drops, slot one drops at once, the
      // fifth packet goes over the global limit. Then new windows clear everything.
      send_packet(16'h0000, 32'd5);
      send_packet(16'h0000, 32'd5);
      send_packet(16'hFFFF, 32'd5);
      send_packet(16'h1234, 32'd5);
      send_packet(16'h1234, 32'd5);
      send_packet(16'hFFFF, 32'd6);
      send_packet(16'h0000, 32'hFFFF_FFFF);
      send_packet(16'h0000, 32'hFFFF_FFFF);
      drain();

      // An unlimited global budget; re-enabling slots zero and one clears their
      // counts while slot two, which stays on, keeps counting.
      csr_write(RegGlobalLimit, 32'hFFFF_FFFF);
      csr_write(RegSlotEnable, 32'd4);
      csr_write(RegSlotEnable, 32'd7);
      csr_idle();
      send_packet(16'hFFFF, 32'hFFFF_FFFF);
      send_packet(16'h0000, 32'hFFFF_FFFF);
      drain();

      // With slot one off the shared type falls through to slot two.
      csr_write(RegSlotEnable, 32'd5);
      csr_idle();
      send_packet(16'hFFFF, 32'hFFFF_FFFF);
      drain();

      // With no slot enabled only the global budget applies.
      csr_write(RegSlotEnable, 32'd0);
      csr_idle();
      send_packet(16'h0000, 32'hFFFF_FFFF);
      drain();

      // Random phases. Each one draws a small pool of packet types, reprograms some
      // or all registers, types from that pool, while the block is idle, then sends packets
      // in windows of random length. Most packets carry a pooled type so that slot
      // matches, duplicate slots and limit hits are common.
      random_sent = 0;
      now_time    = '0;
      prev_time   = '0;
      window_left = 0;
      while (random_sent < RandomItems) begin
         for (int p = 0; p < PoolSize; p++) begin
            case ($urandom_range(0, 3))
               0:       type_pool[p] = '0;
               1:       type_pool[p] = '1;
               default: type_pool[p] = TypeWidth'($urandom);
            endcase
         end

         if ($urandom_range(0, 3) != 0) csr_write(RegGlobalLimit, pick_limit(40));
         if ($urandom_range(0, 3) != 0) csr_write(RegSlotEnable, CsrDataWidth'($urandom));
         for (int k = 0; k < SlotMax; k++) begin
            if ($urandom_range(0, 3) != 0)
               csr_write(RegSlotType0 + CsrIndexWidth'(k),
                         {TypeWidth'($urandom), type_pool[$urandom_range(0, PoolSize - 1)]});
            if ($urandom_range(0, 3) != 0)
               csr_write(RegSlotLimit0 + CsrIndexWidth'(k), pick_limit(12));
         end
         if ($urandom_range(0, 2) == 0)
            csr_write(CsrIndexWidth'($urandom_range(FirstUnusedReg, LastCsrIndex)),
                      CsrDataWidth'($urandom));
         // The enable goes last so that the slot counts it clears are not touched
         // again by later writes in the same group.
         if ($urandom_range(0, 2) == 0) csr_write(RegSlotEnable, CsrDataWidth'($urandom));
         csr_idle();

         // Some phases send without any gap at all.
         gappy       = $urandom_range(0, 3) != 0;
         phase_items = $urandom_range(120, 200);
         burst_left  = 0;
         for (int i = 0; i < phase_items; i++) begin
            if (burst_left == 0) begin
               if (gappy) begin
                  req_chan.valid <= 1'b0;
                  repeat ($urandom_range(1, MaxGap)) @(posedge clock);
               end
               burst_left = $urandom_range(1, MaxBurst);
            end
            // A new window steps the time by one, returns to the previous window's
            // time, or jumps anywhere in the range.
            if (window_left == 0) begin
               case ($urandom_range(0, 3))
                  0:       next_time = now_time + 1'b1;
                  1:       next_time = prev_time;
                  default: next_time = TimeWidth'($urandom);
               endcase
               prev_time   = now_time;
               now_time    = next_time;
               window_left = $urandom_range(1, 30);
            end
            window_left--;
            send_packet(($urandom_range(0, 4) != 0) ? type_pool[$urandom_range(0, PoolSize - 1)]
                                                    : TypeWidth'($urandom),
                        now_time);
            burst_left--;
         end
         random_sent += phase_items;
         drain();
      end

      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/fwprl_pkg.sv
rtl/fwprl_if.sv
rtl/fwprl_csr.sv
rtl/fwprl_core.sv
rtl/fixed_window_packet_rate_limiter.sv
tb/sv/packet_drop_checker.sv
tb/sv/testbench.sv
